// ===== sv/hgr_pkg.sv =====
package hgr_pkg;

  localparam int STRIPE_LINES = 4;
  localparam logic [7:0] GREY_LEVEL = 8'd250;
  localparam logic [7:0] CHAN_MAX = 8'd255;

  localparam logic [2:0] CFG_HUE         = 3'd0;
  localparam logic [2:0] CFG_SATURATION  = 3'd1;
  localparam logic [2:0] CFG_START_VALUE = 3'd2;
  localparam logic [2:0] CFG_END_VALUE   = 3'd3;
  localparam logic [2:0] CFG_TITLE_LINES = 3'd4;
  localparam logic [2:0] CFG_IMAGE_LINES = 3'd5;
  localparam logic [2:0] CFG_TOP_FIRST   = 3'd6;

  localparam logic [2:0] SECT_RED_YEL = 3'd0;
  localparam logic [2:0] SECT_YEL_GRN = 3'd1;
  localparam logic [2:0] SECT_GRN_CYN = 3'd2;
  localparam logic [2:0] SECT_CYN_BLU = 3'd3;
  localparam logic [2:0] SECT_BLU_MAG = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } hgr_div_stat_t;

endpackage

// ===== sv/hgr_div.sv =====
module hgr_div import hgr_pkg::*; #(
  parameter int QW = 24,
  parameter int DW = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [QW+DW-1:0]   num,
  input  logic [DW-1:0]      den,
  output hgr_div_stat_t      stat,
  output logic [QW-1:0]      quo
);

  localparam int CNW = $clog2(QW + 1);

  logic [DW-1:0]  rem_r, rem_nxt;
  logic [QW-1:0]  q_r, q_nxt;
  logic [CNW-1:0] cnt_r;
  logic           busy_r, done_r;
  logic [DW:0]    trial;
  logic           ge;

  // restoring step: one quotient bit per cycle
  always_comb begin
    trial = {rem_r, q_r[QW-1]};
    ge = trial >= {1'b0, den};
    rem_nxt = ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
    q_nxt = {q_r[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNW'(1);
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[QW+DW-1:QW];
      q_r   <= num[QW-1:0];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo = q_r;

endmodule

// ===== sv/hgr_mul.sv =====
module hgr_mul import hgr_pkg::*; #(
  parameter int AW = 24,
  parameter int BW = 17
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  logic [AW+BW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= (AW+BW)'(a) * (AW+BW)'(b);
  end

  assign p = p_r;

endmodule

// ===== sv/hsv_gradient_row_generator_unit.sv =====
// Channel  | Direction | Handshake              | Word
// in_      | in        | in_valid / in_ready    | in_restart
// out_     | out       | out_valid / out_ready  | out_red, out_green, out_blue,
//          |           |                        | out_line_index, out_last_row
// cfg_     | in        | cfg_we (no wait)       | cfg_index, cfg_data
//
// One word at a time. Only ramp rows pass the RAMP and DIVD states; stripe rows go from
// CLASS to FIN. The ramp step uses the shared restoring divider (one quotient bit per
// cycle); title and ramp rows make five passes through the shared multiplier.
// The last step stalls while a previous word still waits for out_ready.
// rst_n is synchronous; it clears the sequencer and row counter and loads config defaults.
// A finished word waits in the output register; a new input word is taken meanwhile.
module hsv_gradient_row_generator_unit import hgr_pkg::*; #(
  parameter int MAX_LINES = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [9:0]  out_line_index,
  output logic        out_last_row,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int LW = $clog2(MAX_LINES);
  localparam int HW = LW + 1;
  localparam int CW = (HW > 12) ? HW : 12;
  localparam int DW = (HW > 8) ? HW : 8;
  localparam int VW = 8 + FRAC_BITS;
  localparam int QW = VW;
  localparam int NW = QW + DW;
  localparam int SW = FRAC_BITS + 1;
  localparam int PW = VW + SW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LINE  = 3'd1;
  localparam logic [2:0] ST_CLASS = 3'd2;
  localparam logic [2:0] ST_RAMP  = 3'd3;
  localparam logic [2:0] ST_DIVD  = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  localparam logic [1:0] KIND_TITLE = 2'd0;
  localparam logic [1:0] KIND_GREY  = 2'd1;
  localparam logic [1:0] KIND_RAMP  = 2'd2;

  localparam logic [2:0] MUL_LAST = 3'd5;

  localparam logic [SW-1:0] FX_ONE = SW'(1) << FRAC_BITS;

  // s = sat * (2^F div 255) + (sat * (2^F mod 255)) / 255
  localparam logic [SW-1:0] SAT_STEP_Q = SW'((64'd1 << FRAC_BITS) / 64'd255);
  localparam logic [7:0]    SAT_STEP_R = 8'((64'd1 << FRAC_BITS) % 64'd255);

  // config
  logic [7:0]  hue_r, sat_r, start_r, end_r;
  logic [10:0] title_r, image_r;
  logic        top_first_r;

  // sequencer
  logic [2:0]    state_r;
  logic [2:0]    step_r;
  logic          restart_r;
  logic [LW-1:0] cnt_r;
  logic [LW-1:0] line_r;
  logic          last_r;
  logic [1:0]    kind_r;
  logic [HW-1:0] n_r, j_r;
  logic [VW-1:0] v_r;
  logic [SW-1:0] s_r, sf_r, s1f_r;
  logic [7:0]    m_r, nn_r, k_r;
  logic [NW-1:0] div_num_r;
  logic [DW-1:0] div_den_r;
  logic          div_go_r;

  // output register
  logic       out_valid_r;
  logic [7:0] red_r, green_r, blue_r;
  logic [9:0] idx_r;
  logic       lastq_r;

  hgr_div_stat_t div_stat;
  logic [QW-1:0] div_quo;
  logic [VW-1:0] mul_a;
  logic [SW-1:0] mul_b;
  logic [PW-1:0] mul_p;

  logic [CW-1:0]     il_w, h_w, tl_w, line_w, ramp0_w;
  logic [HW-1:0]     h;
  logic [LW-1:0]     c;
  logic [9:0]        h3;
  logic [2:0]        sector;
  logic [FRAC_BITS-1:0] f;
  logic [7:0]        diff;
  logic [8+HW-1:0]   dj;
  logic [7:0]        vi;
  logic [15:0]       sat_rb, sat_rq;
  logic [SW-1:0]     s_w;
  logic [7:0]        r_fin, g_fin, b_fin;
  logic              out_free;
  logic              in_acc;

  function automatic logic [7:0] rnd_sat(input logic [PW-1:0] p);
    logic [VW+1:0] t;
    logic [VW+1:0] u;
    t = (VW+2)'(p >> FRAC_BITS) + ((VW+2)'(1) << (FRAC_BITS - 1));
    u = t >> FRAC_BITS;
    return (u > (VW+2)'(255)) ? CHAN_MAX : u[7:0];
  endfunction

  hgr_div #(.QW(QW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  hgr_mul #(.AW(VW), .BW(SW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    il_w = CW'(image_r);
    if (il_w == '0) begin
      h_w = CW'(1);
    end else if (il_w > CW'(MAX_LINES)) begin
      h_w = CW'(MAX_LINES);
    end else begin
      h_w = il_w;
    end
    h = HW'(h_w);
    c = (restart_r || (HW'(cnt_r) >= h)) ? '0 : cnt_r;
    tl_w = CW'(title_r);
    line_w = CW'(line_r);
    ramp0_w = (tl_w != '0) ? tl_w + CW'(STRIPE_LINES) : '0;
    h3 = 10'(hue_r) * 10'd3;
    sector = h3[9:7];
    f = FRAC_BITS'(h3[6:0]) << (FRAC_BITS - 7);
    diff = (start_r > end_r) ? start_r - end_r : end_r - start_r;
    dj = (8+HW)'(diff) * (8+HW)'(j_r);
    vi = v_r[VW-1:FRAC_BITS];
    sat_rb = 16'(sat_r) * 16'(SAT_STEP_R);
    sat_rq = (sat_rb + (sat_rb >> 8) + 16'd1) >> 8;
    s_w = SW'(sat_r) * SAT_STEP_Q + SW'(sat_rq);
  end

  always_comb begin
    unique case (step_r)
      3'd0: begin
        mul_a = VW'(s_r);
        mul_b = SW'(f);
      end
      3'd1: begin
        mul_a = VW'(s_r);
        mul_b = FX_ONE - SW'(f);
      end
      3'd2: begin
        mul_a = v_r;
        mul_b = FX_ONE - s_r;
      end
      3'd3: begin
        mul_a = v_r;
        mul_b = FX_ONE - sf_r;
      end
      default: begin
        mul_a = v_r;
        mul_b = FX_ONE - s1f_r;
      end
    endcase
  end

  always_comb begin
    if (kind_r == KIND_GREY) begin
      r_fin = GREY_LEVEL;
      g_fin = GREY_LEVEL;
      b_fin = GREY_LEVEL;
    end else if (sat_r == '0) begin
      r_fin = vi;
      g_fin = vi;
      b_fin = vi;
    end else begin
      unique case (sector)
        SECT_RED_YEL: begin
          r_fin = vi;   g_fin = k_r;  b_fin = m_r;
        end
        SECT_YEL_GRN: begin
          r_fin = nn_r; g_fin = vi;   b_fin = m_r;
        end
        SECT_GRN_CYN: begin
          r_fin = m_r;  g_fin = vi;   b_fin = k_r;
        end
        SECT_CYN_BLU: begin
          r_fin = m_r;  g_fin = nn_r; b_fin = vi;
        end
        SECT_BLU_MAG: begin
          r_fin = k_r;  g_fin = m_r;  b_fin = vi;
        end
        default: begin
          r_fin = vi;   g_fin = m_r;  b_fin = nn_r;
        end
      endcase
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_r       <= 8'd0;
      sat_r       <= 8'd0;
      start_r     <= 8'd240;
      end_r       <= 8'd50;
      title_r     <= 11'd80;
      image_r     <= 11'd512;
      top_first_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HUE:         hue_r       <= cfg_data[7:0];
        CFG_SATURATION:  sat_r       <= cfg_data[7:0];
        CFG_START_VALUE: start_r     <= cfg_data[7:0];
        CFG_END_VALUE:   end_r       <= cfg_data[7:0];
        CFG_TITLE_LINES: title_r     <= cfg_data;
        CFG_IMAGE_LINES: image_r     <= cfg_data;
        CFG_TOP_FIRST:   top_first_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_LINE;
          end
        end
        ST_LINE: begin
          cnt_r   <= ((HW'(c) + HW'(1)) >= h) ? '0 : LW'(c + LW'(1));
          state_r <= ST_CLASS;
        end
        ST_CLASS: begin
          if (tl_w != '0 && line_w < tl_w) begin
            step_r  <= '0;
            state_r <= ST_MUL;
          end else if (tl_w != '0 && line_w < ramp0_w) begin
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_RAMP;
          end
        end
        ST_RAMP: begin
          div_go_r <= 1'b1;
          state_r  <= ST_DIVD;
        end
        ST_DIVD: begin
          if (div_stat.done) begin
            step_r  <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (step_r == MUL_LAST) begin
            state_r <= ST_FIN;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        default: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          restart_r <= in_restart;
        end
      end
      ST_LINE: begin
        line_r <= top_first_r ? c : LW'(h - HW'(1) - HW'(c));
        last_r <= (HW'(c) == h - HW'(1));
      end
      ST_CLASS: begin
        n_r <= HW'(h_w - ramp0_w);
        j_r <= HW'(line_w - ramp0_w + CW'(1));
        s_r <= s_w;
        if (tl_w != '0 && line_w < tl_w) begin
          kind_r <= KIND_TITLE;
          v_r    <= VW'(start_r) << FRAC_BITS;
        end else if (tl_w != '0 && line_w < ramp0_w) begin
          kind_r <= KIND_GREY;
        end else begin
          kind_r <= KIND_RAMP;
        end
      end
      ST_RAMP: begin
        div_num_r <= NW'(dj) << FRAC_BITS;
        div_den_r <= DW'(n_r);
      end
      ST_DIVD: begin
        if (div_stat.done) begin
          v_r <= (start_r > end_r) ? (VW'(start_r) << FRAC_BITS) - div_quo
                                   : (VW'(start_r) << FRAC_BITS) + div_quo;
        end
      end
      ST_MUL: begin
        unique case (step_r)
          3'd1: sf_r  <= SW'(mul_p >> FRAC_BITS);
          3'd2: s1f_r <= SW'(mul_p >> FRAC_BITS);
          3'd3: m_r   <= rnd_sat(mul_p);
          3'd4: nn_r  <= rnd_sat(mul_p);
          3'd5: k_r   <= rnd_sat(mul_p);
          default: ;
        endcase
      end
      default: begin
        if (out_free) begin
          red_r   <= r_fin;
          green_r <= g_fin;
          blue_r  <= b_fin;
          idx_r   <= 10'(line_r);
          lastq_r <= last_r;
        end
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_line_index = idx_r;
  assign out_last_row   = lastq_r;

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_go_r |-> !div_stat.busy)
    else $error("divider started while busy");

  a_mul_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (step_r <= MUL_LAST))
    else $error("multiplier step out of range");

  a_no_early_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !$rose(out_valid_r))
    else $error("word presented right after accept");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIVD))
    else $error("divider finished outside a divide state");

endmodule
